@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the segment box block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SBI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbi check failed");

// next-cycle implication
`define SBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbi check failed");

`endif

@@ hdl/sbi_pkg.sv @@
// Types, constants and the hit insertion function of the segment box block.
// No dependencies.
`default_nettype none

package sbi_pkg;

   localparam int NUM_FACES = 6;
   localparam int FRAC_BITS = 12;
   localparam int DIV_STAGES = 4;
   localparam int STEPS_PER_STAGE = 4;

   localparam logic [12:0] T_NONE = 13'h1001;
   localparam logic [12:0] T_ONE = 13'h1000;

   typedef struct packed {
      logic signed [15:0] start_x, start_y, start_z;
      logic signed [15:0] end_x, end_y, end_z;
      logic signed [15:0] box_min_x, box_max_x;
      logic signed [15:0] box_min_y, box_max_y;
      logic signed [15:0] box_min_z, box_max_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         hit_count;
      logic signed [15:0] near_x, near_y, near_z;
      logic [2:0]         near_face;
      logic [12:0]        near_t;
      logic signed [15:0] far_x, far_y, far_z;
      logic [2:0]         far_face;
      logic [12:0]        far_t;
   } rsp_type;

   typedef struct packed {
      logic [12:0] t;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic [2:0]  face;
   } hit_type;

   typedef struct packed {
      hit_type near;
      hit_type far;
   } kept_type;

   localparam hit_type HIT_NONE = '{t: T_NONE, x: '0, y: '0, z: '0, face: '0};
   localparam kept_type KEPT_NONE = '{near: HIT_NONE, far: HIT_NONE};

   function automatic kept_type insert_hit(kept_type k, logic ok, hit_type h);
      kept_type r;
      r = k;
      if (ok) begin
         if (h.t < k.near.t) begin
            r.far = k.near;
            r.near = h;
         end else if (h.t < k.far.t) begin
            r.far = h;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/sbi_chan_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
// Depends on sbi_pkg.
`default_nettype none

interface sbi_req_if;
   logic             valid;
   logic             ready;
   sbi_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sbi_rsp_if;
   logic             valid;
   logic             ready;
   sbi_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/sbi_div.sv @@
// Pipelined restoring divider: q = floor(a * 4096 / b), four stages.
// Flags overflow when the quotient is 8192 or more. Depends on sbi_pkg.
`default_nettype none

module sbi_div (
   input  logic                                  clock,
   input  logic [sbi_pkg::DIV_STAGES-1:0]        en,
   input  logic [16:0]                           a,
   input  logic [16:0]                           b,
   output logic [12:0]                           q,
   output logic                                  ovf
);

   logic [16:0] r_ff   [sbi_pkg::DIV_STAGES];
   logic [16:0] b_ff   [sbi_pkg::DIV_STAGES];
   logic [12:0] q_ff   [sbi_pkg::DIV_STAGES];
   logic        ovf_ff [sbi_pkg::DIV_STAGES];
   logic [16:0] r_in   [sbi_pkg::DIV_STAGES];
   logic [12:0] q_in   [sbi_pkg::DIV_STAGES];
   logic        ovf_in;

   always_comb begin
      logic        ip;
      logic [17:0] r2;
      logic [16:0] r;
      logic [12:0] qa;
      ip = a >= b;
      ovf_in = {1'b0, a} >= {b, 1'b0};
      r_in[0] = ip ? a - b : a;
      q_in[0] = {12'b0, ip};
      for (int s = 1; s < sbi_pkg::DIV_STAGES; s++) begin
         r = r_ff[s-1];
         qa = q_ff[s-1];
         for (int k = 0; k < sbi_pkg::STEPS_PER_STAGE; k++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, b_ff[s-1]}) begin
               r = 17'(r2 - {1'b0, b_ff[s-1]});
               qa = {qa[11:0], 1'b1};
            end else begin
               r = r2[16:0];
               qa = {qa[11:0], 1'b0};
            end
         end
         r_in[s] = r;
         q_in[s] = qa;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0] <= r_in[0];
         q_ff[0] <= q_in[0];
         b_ff[0] <= b;
         ovf_ff[0] <= ovf_in;
      end
      for (int s = 1; s < sbi_pkg::DIV_STAGES; s++) begin
         if (en[s]) begin
            r_ff[s] <= r_in[s];
            q_ff[s] <= q_in[s];
            b_ff[s] <= b_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign q = q_ff[sbi_pkg::DIV_STAGES-1];
   assign ovf = ovf_ff[sbi_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

@@ hdl/sbi_sort.sv @@
// Two-stage ordered insertion of six face hits into the near/far pair,
// with the response register at its end. Depends on sbi_pkg.
`default_nettype none

module sbi_sort (
   input  logic                                    clock,
   input  logic [1:0]                              en,
   input  sbi_pkg::hit_type [sbi_pkg::NUM_FACES-1:0] hit,
   input  logic [sbi_pkg::NUM_FACES-1:0]           ok,
   output sbi_pkg::rsp_type                        rsp
);

   sbi_pkg::kept_type kept_ff;
   sbi_pkg::kept_type kept_in;
   sbi_pkg::hit_type  late_ff [3];
   logic [2:0]        late_ok_ff;
   sbi_pkg::rsp_type  rsp_ff;
   sbi_pkg::rsp_type  rsp_in;

   always_comb begin
      sbi_pkg::kept_type k;
      kept_in = sbi_pkg::KEPT_NONE;
      for (int f = 0; f < 3; f++) begin
         kept_in = sbi_pkg::insert_hit(kept_in, ok[f], hit[f]);
      end
      k = kept_ff;
      for (int f = 0; f < 3; f++) begin
         k = sbi_pkg::insert_hit(k, late_ok_ff[f], late_ff[f]);
      end
      if (k.far.t != sbi_pkg::T_NONE) begin
         rsp_in.hit_count = 2'd2;
      end else if (k.near.t != sbi_pkg::T_NONE) begin
         rsp_in.hit_count = 2'd1;
      end else begin
         rsp_in.hit_count = 2'd0;
      end
      rsp_in.near_x = k.near.x;
      rsp_in.near_y = k.near.y;
      rsp_in.near_z = k.near.z;
      rsp_in.near_face = k.near.face;
      rsp_in.near_t = k.near.t;
      rsp_in.far_x = k.far.x;
      rsp_in.far_y = k.far.y;
      rsp_in.far_z = k.far.z;
      rsp_in.far_face = k.far.face;
      rsp_in.far_t = k.far.t;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         kept_ff <= kept_in;
         for (int f = 0; f < 3; f++) begin
            late_ff[f] <= hit[f+3];
            late_ok_ff[f] <= ok[f+3];
         end
      end
      if (en[1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/segment_box_intersection.sv @@
// Segment against axis-aligned box: six face tests, pipelined.
// Depends on sbi_pkg, sbi_chan_if, sbi_div and sbi_sort.
//
//   channel   dir   beat
//   req_chan  in    segment end points and box bounds
//   rsp_chan  out   hit count, near and far crossing
//
// One beat per cycle in, one per cycle out while rsp_chan is not stalled; ten
// register stages lie between an accepted request and its response.
// Six dividers, four stages each, set the depth.
// Reset clears the stage valid bits only.
// A stage holds only while its successor is full and stalled.
`default_nettype none

module segment_box_intersection (
   input logic        clock,
   input logic        reset,
   sbi_req_if.sink    req_chan,
   sbi_rsp_if.source  rsp_chan
);

   localparam int NS = 10;
   localparam int NF = sbi_pkg::NUM_FACES;

   typedef struct packed {
      logic [2:0][15:0] s;
      logic [2:0][16:0] line;
      logic [2:0][15:0] lo;
      logic [2:0][15:0] hi;
   } geo_type;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   sbi_pkg::req_type in_ff;
   geo_type          geo_in;
   geo_type          geo_ff [1:5];
   logic [NF-1:0]    neg_in, nz_in;
   logic [NF-1:0]    neg_ff [1:5];
   logic [NF-1:0]    nz_ff  [1:5];
   logic [16:0]      a_in [NF];
   logic [16:0]      b_in [NF];
   logic [16:0]      a_ff [NF];
   logic [16:0]      b_ff [NF];
   logic [12:0]      q_w [NF];
   logic             ovf_w [NF];

   logic [NF-1:0]           ok6_in, ok6_ff;
   logic signed [29:0]      prod_in [NF][3];
   logic signed [29:0]      prod_ff [NF][3];
   logic [12:0]             t6_ff [NF];
   geo_type                 geo6_ff;

   logic [NF-1:0]                   ok7_in, ok7_ff;
   sbi_pkg::hit_type [NF-1:0]       hit7_in, hit7_ff;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_chan.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_chan.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // face setup
   always_comb begin
      logic [15:0] sd, pd, ld16;
      logic [16:0] ld, diff;
      int          axis;
      geo_in.s[0] = in_ff.start_x;
      geo_in.s[1] = in_ff.start_y;
      geo_in.s[2] = in_ff.start_z;
      geo_in.line[0] = {in_ff.end_x[15], in_ff.end_x} - {in_ff.start_x[15], in_ff.start_x};
      geo_in.line[1] = {in_ff.end_y[15], in_ff.end_y} - {in_ff.start_y[15], in_ff.start_y};
      geo_in.line[2] = {in_ff.end_z[15], in_ff.end_z} - {in_ff.start_z[15], in_ff.start_z};
      geo_in.lo[0] = in_ff.box_min_x;
      geo_in.lo[1] = in_ff.box_min_y;
      geo_in.lo[2] = in_ff.box_min_z;
      geo_in.hi[0] = in_ff.box_max_x;
      geo_in.hi[1] = in_ff.box_max_y;
      geo_in.hi[2] = in_ff.box_max_z;
      for (int f = 0; f < NF; f++) begin
         axis = f >> 1;
         if (f[0] == 1'b0) begin
            sd = 16'(-geo_in.s[axis]);
            pd = 16'(-geo_in.lo[axis]);
            ld = 17'(-geo_in.line[axis]);
            if (axis != 0) begin
               ld16 = ld[15:0];
               ld = {ld16[15], ld16};
            end
         end else begin
            sd = geo_in.s[axis];
            pd = geo_in.hi[axis];
            ld = geo_in.line[axis];
         end
         diff = {pd[15], pd} - {sd[15], sd};
         a_in[f] = diff[16] ? 17'(-diff) : diff;
         b_in[f] = ld[16] ? 17'(-ld) : ld;
         neg_in[f] = diff[16] ^ ld[16];
         nz_in[f] = ld != 17'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         in_ff <= req_chan.data;
      end
      if (en[1]) begin
         geo_ff[1] <= geo_in;
         neg_ff[1] <= neg_in;
         nz_ff[1] <= nz_in;
         a_ff <= a_in;
         b_ff <= b_in;
      end
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) begin
            geo_ff[k] <= geo_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            nz_ff[k] <= nz_ff[k-1];
         end
      end
   end

   for (genvar f = 0; f < NF; f++) begin : g_div
      sbi_div u_div (
         .clock (clock),
         .en    (en[5:2]),
         .a     (a_ff[f]),
         .b     (b_ff[f]),
         .q     (q_w[f]),
         .ovf   (ovf_w[f])
      );
   end

   // range check and point products
   always_comb begin
      logic [12:0] q;
      for (int f = 0; f < NF; f++) begin
         q = q_w[f];
         ok6_in[f] = nz_ff[5][f] && !ovf_w[f] && !(q[12] && (q[11:0] != 12'd0))
                     && (!neg_ff[5][f] || (q == 13'd0));
         for (int i = 0; i < 3; i++) begin
            prod_in[f][i] = $signed({{13{geo_ff[5].line[i][16]}}, geo_ff[5].line[i]})
                            * $signed({17'b0, q});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         ok6_ff <= ok6_in;
         prod_ff <= prod_in;
         t6_ff <= q_w;
         geo6_ff <= geo_ff[5];
      end
   end

   // crossing point and bounds
   always_comb begin
      logic [17:0]      sh;
      logic [2:0][15:0] pt;
      logic             inb;
      for (int f = 0; f < NF; f++) begin
         inb = 1'b1;
         for (int i = 0; i < 3; i++) begin
            sh = 18'(prod_ff[f][i] >>> sbi_pkg::FRAC_BITS);
            pt[i] = geo6_ff.s[i] + sh[15:0];
            if (i != (f >> 1)) begin
               if ($signed(pt[i]) < $signed(geo6_ff.lo[i])
                   || $signed(pt[i]) > $signed(geo6_ff.hi[i])) begin
                  inb = 1'b0;
               end
            end
         end
         ok7_in[f] = ok6_ff[f] && inb;
         hit7_in[f] = '{t: t6_ff[f], x: pt[0], y: pt[1], z: pt[2], face: 3'(f)};
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         ok7_ff <= ok7_in;
         hit7_ff <= hit7_in;
      end
   end

   sbi_sort u_sort (
      .clock (clock),
      .en    (en[9:8]),
      .hit   (hit7_ff),
      .ok    (ok7_ff),
      .rsp   (rsp_chan.data)
   );

   assign rsp_chan.valid = v_ff[NS-1];

endmodule

`default_nettype wire

@@ hdl/sbi_checker.sv @@
// Port-level checks on the response beats of segment_box_intersection.
// Depends on sbi_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module sbi_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sbi_pkg::rsp_type rsp_data
);

   `SBI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `SBI_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_data.hit_count != 2'd3)
   `SBI_ASSERT_NOW(a_none_empty, clock, reset, rsp_valid && rsp_data.hit_count == 2'd0, rsp_data.near_t == sbi_pkg::T_NONE && rsp_data.far_t == sbi_pkg::T_NONE && rsp_data.near_face == 3'd0)
   `SBI_ASSERT_NOW(a_one_hit, clock, reset, rsp_valid && rsp_data.hit_count == 2'd1, rsp_data.near_t <= sbi_pkg::T_ONE && rsp_data.far_t == sbi_pkg::T_NONE)
   `SBI_ASSERT_NOW(a_two_order, clock, reset, rsp_valid && rsp_data.hit_count == 2'd2, rsp_data.near_t <= rsp_data.far_t && rsp_data.far_t <= sbi_pkg::T_ONE)

endmodule

bind segment_box_intersection sbi_checker u_sbi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire
